FILE: rtl/core/fas_pkg.sv
// Shared constants, codes and control types for the frame animation sequencer.
`default_nettype none

package fas_pkg;

  // Table and walk limits
  localparam int MaxFrames      = 64;
  localparam int MaxStepsPerTick = 64;

  // Field widths
  localparam int FRAME_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int TIME_W    = 20;
  localparam int ELAPSED_W = 21;
  localparam int STEP_W    = $clog2(MaxStepsPerTick + 1);
  localparam int ADDR_W    = $clog2(MaxFrames);

  // Packed stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  localparam int CMD_W      = 2;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd3;

  // Direction modes
  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_REV  = 2'd1;
  localparam logic [1:0] MODE_PING = 2'd2;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_DIR   = 2'd0;
  localparam logic [1:0] REG_LOOP  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  // Elapsed time saturation value
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  // Commands from controller to datapath
  typedef struct packed {
    logic start_tick;
    logic play;
    logic stop;
    logic load;
    logic step;
    logic out_load;
  } fas_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic tick_go;
    logic walk_end;
  } fas_stat_t;

  // Configuration register set
  typedef struct packed {
    logic [1:0]         direction_mode;
    logic               loop_enable;
    logic [COUNT_W-1:0] frame_count;
  } fas_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/frame_animation_sequencer.sv
// Top level of the frame animation sequencer: stream ports, config port, core wiring.
//
//  port group   dir  contents
//  s_*          in   command requests (tick, play, stop, load)
//  m_*          out  one status result per request
//  p*           cfg  direction_mode, loop_enable, frame_count registers
//
// Play, stop and load go from acceptance straight to the result state. A tick
// does too when not playing; else it walks frame advances (at most 64), each
// through a table read state and a compare state, until the frame's time is
// not used up, the cap is hit or the clip ends. Reset clears play state and
// registers, not the duration table. A waiting result does not block the next
// request; a new result waits for the output register to free up.
`default_nettype none

module frame_animation_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // tdata: delta_us[19:0], frame_slot[25:20], duration_us[45:26], zero fill
  input  wire logic [fas_pkg::IN_DATA_W-1:0]    s_tdata,
  // tuser: command[1:0]
  input  wire logic [fas_pkg::CMD_W-1:0]        s_tuser,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // tdata: frame_index[5:0], is_playing[6], advanced[7], step_limit_hit[8], zero fill
  output logic      [fas_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fas_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [fas_pkg::PDATA_W-1:0]      pwdata,
  output logic      [fas_pkg::PDATA_W-1:0]      prdata,
  output logic                                  pready
);
  import fas_pkg::*;

  fas_cfg_t          cfg;
  fas_cmd_t          cmd;
  fas_stat_t         stat;
  logic [FRAME_W-1:0] frame_index;
  logic              is_playing;
  logic              advanced;
  logic              step_limit_hit;

  fas_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_cmd    (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fas_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .delta_us       (s_tdata[19:0]),
    .frame_slot     (s_tdata[25:20]),
    .duration_us    (s_tdata[45:26]),
    .stat           (stat),
    .frame_index    (frame_index),
    .is_playing     (is_playing),
    .advanced       (advanced),
    .step_limit_hit (step_limit_hit)
  );

  // Result packing
  assign m_tdata = {7'd0, step_limit_hit, advanced, is_playing, frame_index};

endmodule

`default_nettype wire

FILE: rtl/core/fas_regs.sv
// APB-style configuration registers for the frame animation sequencer.
`default_nettype none

module fas_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fas_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [fas_pkg::PDATA_W-1:0]  pwdata,
  output logic      [fas_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output fas_pkg::fas_cfg_t                 cfg
);
  import fas_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction_mode <= MODE_FWD;
      cfg.loop_enable    <= 1'b1;
      cfg.frame_count    <= COUNT_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DIR:   cfg.direction_mode <= pwdata[1:0];
        REG_LOOP:  cfg.loop_enable    <= pwdata[0];
        REG_COUNT: cfg.frame_count    <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_DIR:   prdata = PDATA_W'(cfg.direction_mode);
      REG_LOOP:  prdata = PDATA_W'(cfg.loop_enable);
      REG_COUNT: prdata = PDATA_W'(cfg.frame_count);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/fas_ctrl.sv
// Controller state machine: command dispatch, frame walk sequencing, result handoff.
`default_nettype none

module fas_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [fas_pkg::CMD_W-1:0] s_cmd,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  input  wire fas_pkg::fas_stat_t       stat,
  output fas_pkg::fas_cmd_t             cmd
);
  import fas_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_CHECK  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (s_cmd)
            CMD_TICK: begin
              cmd.start_tick = 1'b1;
              state_next     = stat.tick_go ? S_READ : S_FINISH;
            end
            CMD_PLAY: begin
              cmd.play   = 1'b1;
              state_next = S_FINISH;
            end
            CMD_STOP: begin
              cmd.stop   = 1'b1;
              state_next = S_FINISH;
            end
            default: begin
              cmd.load   = 1'b1;
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        cmd.step   = 1'b1;
        state_next = stat.walk_end ? S_FINISH : S_READ;
      end
      default: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fas_dp.sv
// Datapath: duration table, playback state, frame advance logic and result register.
`default_nettype none

module fas_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fas_pkg::fas_cfg_t             cfg,
  input  wire fas_pkg::fas_cmd_t             cmd,
  input  wire logic [fas_pkg::TIME_W-1:0]    delta_us,
  input  wire logic [fas_pkg::FRAME_W-1:0]   frame_slot,
  input  wire logic [fas_pkg::TIME_W-1:0]    duration_us,
  output fas_pkg::fas_stat_t                 stat,
  output logic      [fas_pkg::FRAME_W-1:0]   frame_index,
  output logic                               is_playing,
  output logic                               advanced,
  output logic                               step_limit_hit
);
  import fas_pkg::*;

  // Duration table, registered read
  logic [TIME_W-1:0] dur_mem [MaxFrames];
  logic [TIME_W-1:0] rd_dur;

  // Playback state
  logic [ELAPSED_W-1:0] elapsed;
  logic [FRAME_W-1:0]   cur_frame;
  logic                 playing;
  logic                 bounce;
  logic                 adv_flag;
  logic                 limit_flag;
  logic [STEP_W-1:0]    steps;

  // Combinational terms
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_m1;
  logic [COUNT_W-1:0]   count_m2;
  logic [COUNT_W-1:0]   frame_p1;
  logic [FRAME_W-1:0]   clamp_frame;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic [ELAPSED_W-1:0] elapsed_sub;
  logic                 hold;
  logic                 cap;
  logic [FRAME_W-1:0]   nx_frame;
  logic                 nx_bounce;
  logic                 nx_play;
  logic                 nx_clear;

  // Clip length saturated to the table depth
  assign count    = (cfg.frame_count > COUNT_W'(MaxFrames)) ? COUNT_W'(MaxFrames)
                                                           : cfg.frame_count;
  assign count_m1 = count - COUNT_W'(1);
  assign count_m2 = count - COUNT_W'(2);
  assign frame_p1 = COUNT_W'(cur_frame) + COUNT_W'(1);

  // Tick entry: clamp frame, add elapsed with saturation
  assign clamp_frame = (COUNT_W'(cur_frame) >= count) ? count_m1[FRAME_W-1:0] : cur_frame;
  assign elapsed_sum = (ELAPSED_W+1)'(elapsed) + (ELAPSED_W+1)'(delta_us);
  assign elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];

  // Walk checks against the frame just read
  assign hold        = (rd_dur != '0) && (elapsed < ELAPSED_W'(rd_dur));
  assign cap         = (steps >= STEP_W'(MaxStepsPerTick));
  assign elapsed_sub = elapsed - ELAPSED_W'(rd_dur);

  assign stat.tick_go  = playing & (count != '0);
  assign stat.walk_end = hold | cap | ~nx_play;

  // One frame advance
  always_comb begin
    nx_frame  = cur_frame;
    nx_bounce = bounce;
    nx_play   = playing;
    nx_clear  = 1'b0;
    if (cfg.direction_mode == MODE_REV) begin
      if (cur_frame != '0) begin
        nx_frame = cur_frame - FRAME_W'(1);
      end else if (cfg.loop_enable) begin
        nx_frame = count_m1[FRAME_W-1:0];
      end else begin
        nx_play  = 1'b0;
        nx_clear = 1'b1;
      end
    end else if (cfg.direction_mode == MODE_PING) begin
      if (!bounce && (frame_p1 < count)) begin
        nx_frame = frame_p1[FRAME_W-1:0];
      end else if (bounce && (cur_frame != '0)) begin
        nx_frame = cur_frame - FRAME_W'(1);
      end else begin
        nx_bounce = ~bounce;
        if (count == COUNT_W'(1)) begin
          // single frame: flip and restart the frame time
          nx_play  = cfg.loop_enable;
          nx_clear = 1'b1;
        end else if (bounce) begin
          // back at frame 0 after the return pass
          if (!cfg.loop_enable) begin
            nx_play  = 1'b0;
            nx_clear = 1'b1;
          end else begin
            nx_frame = FRAME_W'(1);
          end
        end else begin
          nx_frame = count_m2[FRAME_W-1:0];
        end
      end
    end else begin
      if (frame_p1 < count) begin
        nx_frame = frame_p1[FRAME_W-1:0];
      end else if (cfg.loop_enable) begin
        nx_frame = '0;
      end else begin
        nx_play  = 1'b0;
        nx_clear = 1'b1;
      end
    end
  end

  // Table write and read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur_mem[frame_slot[ADDR_W-1:0]] <= duration_us;
    end
    rd_dur <= dur_mem[cur_frame[ADDR_W-1:0]];
  end

  // Playback state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed    <= '0;
      cur_frame  <= '0;
      playing    <= 1'b0;
      bounce     <= 1'b0;
      adv_flag   <= 1'b0;
      limit_flag <= 1'b0;
      steps      <= '0;
    end else begin
      if (cmd.start_tick || cmd.play || cmd.stop || cmd.load) begin
        adv_flag   <= 1'b0;
        limit_flag <= 1'b0;
        steps      <= '0;
      end
      if (cmd.start_tick && stat.tick_go) begin
        cur_frame <= clamp_frame;
        elapsed   <= elapsed_sat;
      end
      if (cmd.play && (count != '0)) begin
        playing   <= 1'b1;
        elapsed   <= '0;
        bounce    <= 1'b0;
        cur_frame <= (cfg.direction_mode == MODE_REV) ? count_m1[FRAME_W-1:0] : '0;
      end
      if (cmd.stop) begin
        playing <= 1'b0;
      end
      if (cmd.step && !hold) begin
        if (cap) begin
          limit_flag <= 1'b1;
        end else begin
          elapsed   <= nx_clear ? '0 : elapsed_sub;
          cur_frame <= nx_frame;
          bounce    <= nx_bounce;
          playing   <= nx_play;
          adv_flag  <= 1'b1;
          steps     <= steps + STEP_W'(1);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frame_index    <= cur_frame;
      is_playing     <= playing;
      advanced       <= adv_flag;
      step_limit_hit <= limit_flag;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the frame animation sequencer: queued requests, predictor, checker.
`timescale 1ns / 100ps

module tb_top;
  import fas_pkg::*;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [TIME_W-1:0]  delta;
    logic [FRAME_W-1:0] slot;
    logic [TIME_W-1:0]  dur;
  } anim_req_t;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic               playing;
    logic               advanced;
    logic               limit_hit;
  } anim_status_t;

  // DUT connections; every input starts at a known value
  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [CMD_W-1:0]      s_tuser  = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [PADDR_W-1:0]    paddr    = '0;
  logic [PDATA_W-1:0]    pwdata   = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // Predicted player state and register copy
  logic [TIME_W-1:0]    dur_table [MaxFrames];
  logic [ELAPSED_W-1:0] elapsed   = '0;
  logic [FRAME_W-1:0]   cur_frame = '0;
  bit                   playing   = 1'b0;
  bit                   going_back = 1'b0;
  logic [1:0]           cfg_dir   = MODE_FWD;
  bit                   cfg_loop  = 1'b1;
  logic [COUNT_W-1:0]   cfg_count = 7'd1;

  anim_req_t    pending_reqs [$];
  anim_status_t expected_status [$];
  anim_req_t    on_bus;

  int mismatches   = 0;
  int results_seen = 0;
  int send_gap     = 0;
  int ready_hold   = 0;
  bit steady_phase = 1'b0;
  bit long_hold_done = 1'b0;

  frame_animation_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int clip_frames();
    return (cfg_count > MaxFrames) ? MaxFrames : int'(cfg_count);
  endfunction

  function automatic void end_clip();
    playing = 1'b0;
    elapsed = '0;
  endfunction

  // One frame step in the current play order
  function automatic void advance_one(int count);
    if (cfg_dir == MODE_REV) begin
      if (cur_frame > 0) cur_frame = cur_frame - 1'b1;
      else if (cfg_loop) cur_frame = FRAME_W'(count - 1);
      else end_clip();
    end else if (cfg_dir == MODE_PING) begin
      if (!going_back && cur_frame + 1 < count) begin
        cur_frame = cur_frame + 1'b1;
      end else if (going_back && cur_frame > 0) begin
        cur_frame = cur_frame - 1'b1;
      end else begin
        // bounce at an end
        going_back = !going_back;
        if (count == 1) begin
          playing = cfg_loop;
          elapsed = '0;
        end else if (!going_back) begin
          if (!cfg_loop) end_clip();
          else cur_frame = 6'd1;
        end else begin
          cur_frame = FRAME_W'(count - 2);
        end
      end
    end else begin
      // forward, and the unused mode code
      if (cur_frame + 1 < count) cur_frame = cur_frame + 1'b1;
      else if (cfg_loop) cur_frame = '0;
      else end_clip();
    end
  endfunction

  function automatic anim_status_t apply_request(anim_req_t r);
    int               count;
    int               steps;
    logic [ELAPSED_W:0] sum;
    logic [TIME_W-1:0] d;
    bit               walking;
    anim_status_t     st;
    count        = clip_frames();
    steps        = 0;
    st.advanced  = 1'b0;
    st.limit_hit = 1'b0;
    case (r.cmd)
      CMD_TICK: begin
        if (playing && count != 0) begin
          if (cur_frame >= count) cur_frame = FRAME_W'(count - 1);
          sum     = elapsed + r.delta;
          elapsed = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
          walking = 1'b1;
          // walk across every frame the elapsed time covers, up to the cap
          while (walking) begin
            d = dur_table[cur_frame];
            if (d != 0 && elapsed < d) begin
              walking = 1'b0;
            end else if (steps >= MaxStepsPerTick) begin
              st.limit_hit = 1'b1;
              walking      = 1'b0;
            end else begin
              if (d != 0) elapsed = elapsed - d;
              advance_one(count);
              st.advanced = 1'b1;
              steps++;
              if (!playing) walking = 1'b0;
            end
          end
        end
      end
      CMD_PLAY: begin
        if (count != 0) begin
          playing    = 1'b1;
          elapsed    = '0;
          going_back = 1'b0;
          cur_frame  = (cfg_dir == MODE_REV) ? FRAME_W'(count - 1) : '0;
        end
      end
      CMD_STOP: playing = 1'b0;
      default:  dur_table[r.slot] = r.dur;
    endcase
    st.frame   = cur_frame;
    st.playing = playing;
    return st;
  endfunction

  // ---------------------------------------------------------------- helpers

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  function automatic void add_req(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] delta,
                                  logic [FRAME_W-1:0] slot, logic [TIME_W-1:0] dur);
    anim_req_t r;
    r.cmd   = cmd;
    r.delta = delta;
    r.slot  = slot;
    r.dur   = dur;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic logic [TIME_W-1:0] rand_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 70) return TIME_W'($urandom_range(1, 128));
    if (r < 90) return TIME_W'($urandom_range(1, 2000));
    return TIME_W'($urandom);
  endfunction

  function automatic logic [TIME_W-1:0] rand_dur();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 80) return TIME_W'($urandom_range(1, 64));
    if (r < 95) return TIME_W'($urandom_range(65, 1000));
    return TIME_W'($urandom);
  endfunction

  // Random request; unused fields carry random content too
  function automatic anim_req_t random_req();
    anim_req_t r;
    int        pick;
    pick    = $urandom_range(0, 99);
    r.delta = rand_delta();
    r.slot  = FRAME_W'($urandom_range(0, MaxFrames - 1));
    r.dur   = rand_dur();
    if (pick < 62) r.cmd = CMD_TICK;
    else if (pick < 70) r.cmd = CMD_PLAY;
    else if (pick < 76) r.cmd = CMD_STOP;
    else r.cmd = CMD_LOAD;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Register write: setup phase, then access phase
  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DIR:   cfg_dir   = value[1:0];
      REG_LOOP:  cfg_loop  = value[0];
      REG_COUNT: cfg_count = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [1:0] dir, input bit loop_on,
                            input logic [COUNT_W-1:0] count);
    write_reg(REG_DIR, PDATA_W'(dir));
    write_reg(REG_LOOP, PDATA_W'(loop_on));
    write_reg(REG_COUNT, PDATA_W'(count));
    @(negedge clk);
  endtask

  // Wait until every request is sent and every result is back
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_status.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : feed
    anim_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_status.insert(expected_status.size(), apply_request(on_bus));
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          on_bus   <= nxt;
          s_tdata  <= {2'b00, nxt.dur, nxt.slot, nxt.delta};
          s_tuser  <= nxt.cmd;
          s_tvalid <= 1'b1;
          send_gap <= steady_phase ? 0 : idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result-side ready: random stalls plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      m_tready   <= 1'b0;
    end else if (!long_hold_done && results_seen >= 400) begin
      long_hold_done <= 1'b1;
      ready_hold     <= 600;
      m_tready       <= 1'b0;
    end else if (!steady_phase && $urandom_range(0, 5) == 0) begin
      ready_hold <= idle_len();
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : result_check
    anim_status_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (expected_status.size() == 0) begin
        report_mismatch($sformatf("result 0x%0h with no request outstanding", m_tdata));
      end else begin
        want = expected_status.pop_front();
        if (m_tdata[5:0] !== want.frame)
          report_mismatch($sformatf("frame_index got %0d, expected %0d",
                                    m_tdata[5:0], want.frame));
        if (m_tdata[6] !== want.playing)
          report_mismatch($sformatf("is_playing got %b, expected %b", m_tdata[6], want.playing));
        if (m_tdata[7] !== want.advanced)
          report_mismatch($sformatf("advanced got %b, expected %b", m_tdata[7], want.advanced));
        if (m_tdata[8] !== want.limit_hit)
          report_mismatch($sformatf("step_limit_hit got %b, expected %b",
                                    m_tdata[8], want.limit_hit));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int               n;
    int               k;
    logic [COUNT_W-1:0] cnt;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the whole duration table before anything plays
    for (n = 0; n < MaxFrames; n++)
      add_req(CMD_LOAD, TIME_W'($urandom), FRAME_W'(n), (n % 5 == 4) ? '0 : TIME_W'(20 + n));
    wait_idle();

    // Idle tick, play, partial and multi-frame ticks, stop
    set_config(MODE_FWD, 1'b1, 7'd4);
    add_req(CMD_TICK, 20'd5, 6'd63, 20'hFFFFF);
    add_req(CMD_PLAY, TIME_W'($urandom), 6'd0, '0);
    add_req(CMD_TICK, 20'd0, 6'd0, '0);
    add_req(CMD_TICK, 20'd45, 6'd0, '0);
    add_req(CMD_STOP, 20'hFFFFF, 6'd63, 20'hFFFFF);
    add_req(CMD_TICK, 20'd100, 6'd0, '0);
    add_req(CMD_PLAY, '0, 6'd0, '0);
    // All-zero looping clip: advance cap, then elapsed saturation
    for (n = 0; n < 4; n++) add_req(CMD_LOAD, '0, FRAME_W'(n), '0);
    repeat (3) add_req(CMD_TICK, 20'hFFFFF, 6'd0, '0);
    // Longest durations, consumed from the saturated elapsed time
    for (n = 0; n < 4; n++) add_req(CMD_LOAD, 20'hFFFFF, FRAME_W'(n), 20'hFFFFF);
    add_req(CMD_TICK, 20'd0, 6'd0, '0);
    wait_idle();

    // Single-frame ping-pong without looping stops on its bounce
    set_config(MODE_PING, 1'b0, 7'd1);
    add_req(CMD_LOAD, '0, 6'd0, '0);
    add_req(CMD_PLAY, '0, 6'd0, '0);
    add_req(CMD_TICK, 20'd1, 6'd0, '0);
    wait_idle();

    // Reverse start at the last frame of the largest clip
    set_config(MODE_REV, 1'b0, 7'd64);
    add_req(CMD_PLAY, '0, 6'd0, '0);
    add_req(CMD_TICK, 20'd0, 6'd0, '0);
    wait_idle();

    // Clip shrunk under a playing frame; unused mode code plays forward
    set_config(2'd3, 1'b1, 7'd2);
    add_req(CMD_TICK, 20'd1, 6'd0, '0);
    wait_idle();

    // Empty clip: play and tick change nothing
    set_config(MODE_FWD, 1'b1, 7'd0);
    add_req(CMD_PLAY, '0, 6'd0, '0);
    add_req(CMD_TICK, 20'd50, 6'd0, '0);
    wait_idle();

    // Random phases, each under its own register setting
    for (k = 0; k < 16; k++) begin
      case (k)
        0:       cnt = 7'd1;
        1:       cnt = 7'd64;
        2:       cnt = 7'd2;
        7:       cnt = 7'd0;
        9:       cnt = 7'd127;
        default: cnt = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(1, 64))
                                                   : COUNT_W'($urandom_range(1, 8));
      endcase
      set_config(2'(k % 4), bit'((k / 4) % 2), cnt);
      steady_phase = (k % 5 == 3);
      add_req(CMD_PLAY, rand_delta(), 6'd0, rand_dur());
      for (n = 1; n < 98; n++) pending_reqs.insert(pending_reqs.size(), random_req());
      wait_idle();
    end
    steady_phase = 1'b0;

    // Drain, then allow for the block's longest walk
    wait_idle();
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/fas_pkg.sv
rtl/core/fas_regs.sv
rtl/core/fas_ctrl.sv
rtl/core/fas_dp.sv
rtl/core/frame_animation_sequencer.sv
sim/tb_top.sv
